// ===== rtl/sobel_pkg.sv =====
// Shared types and constants for the Sobel edge threshold stream unit.
// Holds the configuration register indexes, field widths and edge codes.
// No dependencies.
`timescale 1ns / 1ps

package sobel_pkg;

    localparam int PIX_W      = 8;
    localparam int ROWS_W     = 12;
    localparam int COLS_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef logic [PIX_W-1:0]      pixel_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_index_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_ROWS     = 2'd0,
        REG_FRAME_COLS     = 2'd1,
        REG_LOW_THRESHOLD  = 2'd2,
        REG_HIGH_THRESHOLD = 2'd3
    } cfg_reg_t;

    localparam logic [ROWS_W-1:0] FRAME_ROWS_RESET     = 12'd540;
    localparam logic [COLS_W-1:0] FRAME_COLS_RESET     = 11'd960;
    localparam pixel_t            LOW_THRESHOLD_RESET  = 8'd50;
    localparam pixel_t            HIGH_THRESHOLD_RESET = 8'd150;

    localparam pixel_t EDGE_NONE   = 8'd0;
    localparam pixel_t EDGE_WEAK   = 8'd100;
    localparam pixel_t EDGE_STRONG = 8'd255;
    localparam pixel_t MAG_MAX     = 8'd255;

    // The window is complete from the third row and the third column on.
    localparam int WINDOW_START = 2;

endpackage

// ===== rtl/sobel_edge_threshold_stream_unit.sv =====
// Top level of the Sobel edge threshold stream unit.
// Depends on sobel_pkg for register indexes, widths and edge codes.
// A result passes stage 1, stage 2 and the output register, each holding one item.
// Throughput: one item per cycle while m_ready does not stall the output, set by
// the single read and write port of each line store.
// Reset (aresetn low, synchronous) restores the register defaults, clears the
// positions, the window and all stage valid bits; the line stores are not cleared.
`timescale 1ns / 1ps

module sobel_edge_threshold_stream_unit #(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  sobel_pkg::cfg_index_t cfg_index,
    input  sobel_pkg::cfg_data_t  cfg_data,

    // Pixel input channel.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sobel_pkg::pixel_t     s_pixel,

    // Edge result channel.
    output logic                  m_valid,
    input  logic                  m_ready,
    output sobel_pkg::pixel_t     m_edge_value,
    output logic                  m_frame_end
);

    import sobel_pkg::*;

    // Address width of the line stores and the width used for the end of row test.
    localparam int AW   = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int CMPW = (AW + 1 > COLS_W) ? AW + 1 : COLS_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LINE_WIDTH - 1);

    // ------------------------------------------------------------------
    // Configuration registers. The port never stalls; the user must make writes only
    // while the stream is idle; the block does not enforce this or guard the pipeline.
    // ------------------------------------------------------------------
    logic [ROWS_W-1:0] frame_rows_reg;
    logic [COLS_W-1:0] frame_cols_reg;
    pixel_t            low_threshold_reg;
    pixel_t            high_threshold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_rows_reg     <= FRAME_ROWS_RESET;
            frame_cols_reg     <= FRAME_COLS_RESET;
            low_threshold_reg  <= LOW_THRESHOLD_RESET;
            high_threshold_reg <= HIGH_THRESHOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_ROWS:     frame_rows_reg     <= cfg_data[ROWS_W-1:0];
                REG_FRAME_COLS:     frame_cols_reg     <= cfg_data[COLS_W-1:0];
                REG_LOW_THRESHOLD:  low_threshold_reg  <= cfg_data[PIX_W-1:0];
                REG_HIGH_THRESHOLD: high_threshold_reg <= cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Every stage holds one item and moves on whenever the
    // stage after it is empty or moving, so bubbles are squeezed out and a
    // waiting result blocks the input only once stage 1 and stage 2 are both full.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic m_valid_reg;

    logic out_free;
    logic s2_free;
    logic s1_free;
    logic accept;
    logic s1_move;

    assign out_free = !m_valid_reg || m_ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s_ready  = s1_free;
    assign accept   = s_valid && s_ready;
    // An item leaving stage 1 writes its column back to the line stores.
    assign s1_move  = s1_valid_reg && s2_free;

    // ------------------------------------------------------------------
    // Stage 0: position counters. They advance as each item is accepted,
    // and the current column is the read address of both line stores.
    // A row ends when the column reaches or passes the last column (a row
    // length of zero acts as one, any length above the store depth as the depth).
    // ------------------------------------------------------------------
    logic [AW-1:0]     col_reg;
    logic [AW-1:0]     col_next;
    logic [ROWS_W-1:0] row_reg;
    logic [ROWS_W-1:0] row_next;
    logic              last_col;
    logic              last_row;
    logic              window_full;

    assign last_col = (CMPW'(col_reg) + CMPW'(1) >= CMPW'(frame_cols_reg))
                   || (col_reg == LAST_ADDR);
    assign last_row = ({1'b0, row_reg} + {{ROWS_W{1'b0}}, 1'b1}) >= {1'b0, frame_rows_reg};
    assign window_full = (row_reg >= ROWS_W'(WINDOW_START))
                      && (col_reg >= AW'(WINDOW_START));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROWS_W'(1);
        end else begin
            col_next = col_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: the older one holds row r-2 and the newer one row r-1.
    // Each is read at acceptance and written back when the item leaves
    // stage 1 with the pixels that moved down one row.
    // ------------------------------------------------------------------
    pixel_t older_mem [MAX_LINE_WIDTH];
    pixel_t newer_mem [MAX_LINE_WIDTH];
    pixel_t older_q_reg;
    pixel_t newer_q_reg;

    // Stage 1 registers.
    pixel_t        s1_pixel_reg;
    logic [AW-1:0] s1_col_reg;
    logic          s1_full_reg;
    logic          s1_fend_reg;
    logic          fwd_reg;
    pixel_t        fwd_top_reg;
    pixel_t        fwd_mid_reg;

    pixel_t top;
    pixel_t mid;

    // When a row is only one pixel wide, the next item reads the entry that
    // the item in stage 1 writes at the same edge; the written data is then
    // forwarded instead of the stale read.
    assign top = fwd_reg ? fwd_top_reg : older_q_reg;
    assign mid = fwd_reg ? fwd_mid_reg : newer_q_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            older_q_reg <= older_mem[col_reg];
            newer_q_reg <= newer_mem[col_reg];
        end
        if (s1_move) begin
            older_mem[s1_col_reg] <= mid;
            newer_mem[s1_col_reg] <= s1_pixel_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_move && (s1_col_reg == col_reg);
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pixel_reg <= s_pixel;
            s1_col_reg   <= col_reg;
            s1_full_reg  <= window_full;
            s1_fend_reg  <= last_col && last_row;
            fwd_top_reg  <= mid;
            fwd_mid_reg  <= s1_pixel_reg;
        end
    end

    // ------------------------------------------------------------------
    // Window of the two previous columns. Column c-2 is w0, column c-1 is
    // w1, each ordered top, middle, bottom. It shifts as an item leaves
    // stage 1, so the next item always sees the columns of the ones before.
    // ------------------------------------------------------------------
    pixel_t w0_reg [3];
    pixel_t w1_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                w0_reg[i] <= '0;
                w1_reg[i] <= '0;
            end
        end else if (s1_move) begin
            for (int i = 0; i < 3; i++) begin
                w0_reg[i] <= w1_reg[i];
            end
            w1_reg[0] <= top;
            w1_reg[1] <= mid;
            w1_reg[2] <= s1_pixel_reg;
        end
    end

    // Sobel kernels: the window's bottom-right corner is the current pixel.
    logic [9:0]         gx_pos;
    logic [9:0]         gx_neg;
    logic [9:0]         gy_pos;
    logic [9:0]         gy_neg;
    logic signed [11:0] gx;
    logic signed [11:0] gy;

    assign gx_pos = 10'(top) + {1'b0, mid, 1'b0} + 10'(s1_pixel_reg);
    assign gx_neg = 10'(w0_reg[0]) + {1'b0, w0_reg[1], 1'b0} + 10'(w0_reg[2]);
    assign gy_pos = 10'(w0_reg[2]) + {1'b0, w1_reg[2], 1'b0} + 10'(s1_pixel_reg);
    assign gy_neg = 10'(w0_reg[0]) + {1'b0, w1_reg[0], 1'b0} + 10'(top);
    assign gx = $signed({2'b00, gx_pos}) - $signed({2'b00, gx_neg});
    assign gy = $signed({2'b00, gy_pos}) - $signed({2'b00, gy_neg});

    // ------------------------------------------------------------------
    // Stage 2: gradients are registered; magnitude and classification
    // follow into the output register.
    // ------------------------------------------------------------------
    logic signed [11:0] s2_gx_reg;
    logic signed [11:0] s2_gy_reg;
    logic               s2_full_reg;
    logic               s2_fend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_free) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            s2_gx_reg   <= gx;
            s2_gy_reg   <= gy;
            s2_full_reg <= s1_full_reg;
            s2_fend_reg <= s1_fend_reg;
        end
    end

    logic [10:0] abs_gx;
    logic [10:0] abs_gy;
    logic [11:0] mag;
    pixel_t      mag_sat;
    pixel_t      edge_class;

    assign abs_gx  = s2_gx_reg[11] ? 11'(-s2_gx_reg) : s2_gx_reg[10:0];
    assign abs_gy  = s2_gy_reg[11] ? 11'(-s2_gy_reg) : s2_gy_reg[10:0];
    assign mag     = {1'b0, abs_gx} + {1'b0, abs_gy};
    assign mag_sat = (mag > 12'(MAG_MAX)) ? MAG_MAX : mag[PIX_W-1:0];

    // The strong threshold is tested first, so thresholds out of order
    // still give a defined class.
    always_comb begin
        priority if (!s2_full_reg) begin
            edge_class = EDGE_NONE;
        end else if (mag_sat > high_threshold_reg) begin
            edge_class = EDGE_STRONG;
        end else if (mag_sat > low_threshold_reg) begin
            edge_class = EDGE_WEAK;
        end else begin
            edge_class = EDGE_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    pixel_t m_edge_value_reg;
    logic   m_frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s2_valid_reg) begin
            m_edge_value_reg <= edge_class;
            m_frame_end_reg  <= s2_fend_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_edge_value = m_edge_value_reg;
    assign m_frame_end  = m_frame_end_reg;

endmodule

// ===== verif/sobel_edge_threshold_stream_unit_test.sv =====
// Self-checking testbench for sobel_edge_threshold_stream_unit: streams pixel frames through the
// block under random back-pressure and checks every edge result against an in-bench predictor.
// Depends on sobel_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module sobel_edge_threshold_stream_unit_test;

    import sobel_pkg::*;

    localparam int LINE_DEPTH    = 1024;
    localparam int IDLE_PCT      = 21;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_FROM    = 300;
    localparam int QUIET_TO      = 1300;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int ROWS_MAX      = (1 << ROWS_W) - 1;
    localparam int COLS_MAX      = (1 << COLS_W) - 1;

    // One expected result item, in the order of the result channel's fields.
    typedef struct packed {
        pixel_t edge_value;
        logic   frame_end;
    } edge_result_t;

    typedef struct {
        cfg_reg_t  index;
        cfg_data_t data;
    } reg_write_t;

    // Three small frames: a strong falling vertical edge, a flat white frame with no edge,
    // and a gentle vertical ramp that lands in the weak band of the default thresholds.
    localparam pixel_t DIRECTED_PIXELS [27] = '{
        8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd0,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd0,   8'd0,   8'd0,   8'd10,  8'd10,  8'd10,  8'd20,  8'd20,  8'd20
    };

    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index    = REG_FRAME_ROWS;
    cfg_data_t  cfg_data     = '0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    pixel_t     s_pixel      = '0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    pixel_t     m_edge_value;
    logic       m_frame_end;

    sobel_edge_threshold_stream_unit #(
        .MAX_LINE_WIDTH(LINE_DEPTH)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_edge_value(m_edge_value),
        .m_frame_end (m_frame_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Cycle count drives the one long stretch in which neither side idles.
    int unsigned cycle_count = 0;
    wire         quiet       = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Pixels waiting for the driver, expected edge results waiting for the monitor,
    // and register writes waiting for the configuration channel.
    pixel_t       pixel_q[$];
    edge_result_t expected_edges_q[$];
    reg_write_t   reg_write_q[$];
    bit           pixel_held = 1'b0;
    int unsigned  failures   = 0;
    int           walk_level = 128;

    // Predictor state: our own copy of the registers, both line stores, the two trailing
    // window columns and the raster position.
    logic [ROWS_W-1:0] rows_reg;
    logic [COLS_W-1:0] cols_reg;
    pixel_t            low_thr;
    pixel_t            high_thr;
    pixel_t            line_older [LINE_DEPTH];
    pixel_t            line_newer [LINE_DEPTH];
    pixel_t            win_cols   [2][3];
    int unsigned       row_pos;
    int unsigned       col_pos;

    task automatic reset_prediction();
        rows_reg = FRAME_ROWS_RESET;
        cols_reg = FRAME_COLS_RESET;
        low_thr  = LOW_THRESHOLD_RESET;
        high_thr = HIGH_THRESHOLD_RESET;
        foreach (line_older[i]) begin
            line_older[i] = '0;
            line_newer[i] = '0;
        end
        foreach (win_cols[i, j]) begin
            win_cols[i][j] = '0;
        end
        row_pos = 0;
        col_pos = 0;
    endtask

    // A zero size acts as one; a row wider than the line stores is cut to their depth.
    function automatic int unsigned usable_rows(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic int unsigned usable_cols(int unsigned v);
        if (v == 0) begin
            return 1;
        end
        return (v > LINE_DEPTH) ? LINE_DEPTH : v;
    endfunction

    // Computes the edge result of one accepted pixel and advances the predictor state.
    function automatic edge_result_t predict_edge(pixel_t px);
        int unsigned  col;
        pixel_t       top;
        pixel_t       mid;
        int           p00, p01, p02, p10, p12, p20, p21, p22;
        int           gx, gy, mag;
        edge_result_t r;
        col          = col_pos % LINE_DEPTH;
        top          = line_older[col];
        mid          = line_newer[col];
        r.edge_value = EDGE_NONE;
        r.frame_end  = 1'b0;
        // The window ends at the current pixel, so it is complete only from the third
        // row and the third column on; before that the edge value stays at none.
        if (row_pos >= WINDOW_START && col_pos >= WINDOW_START) begin
            p00 = win_cols[0][0];
            p10 = win_cols[0][1];
            p20 = win_cols[0][2];
            p01 = win_cols[1][0];
            p21 = win_cols[1][2];
            p02 = top;
            p12 = mid;
            p22 = px;
            gx  = -p00 - 2 * p10 - p20 + p02 + 2 * p12 + p22;
            gy  = -p00 - 2 * p01 - p02 + p20 + 2 * p21 + p22;
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            if (mag > MAG_MAX) begin
                mag = MAG_MAX;
            end
            // The strong threshold is tested first, so swapped thresholds still give strong.
            if (mag > high_thr) begin
                r.edge_value = EDGE_STRONG;
            end else if (mag > low_thr) begin
                r.edge_value = EDGE_WEAK;
            end
        end
        line_older[col] = mid;
        line_newer[col] = px;
        win_cols[0]     = win_cols[1];
        win_cols[1][0]  = top;
        win_cols[1][1]  = mid;
        win_cols[1][2]  = px;
        // A row or a frame ends when the position reaches or passes the last one, which
        // matters when a size register shrinks in the middle of a frame.
        if (col_pos + 1 >= usable_cols(cols_reg)) begin
            col_pos = 0;
            if (row_pos + 1 >= usable_rows(rows_reg)) begin
                row_pos     = 0;
                r.frame_end = 1'b1;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
        return r;
    endfunction

    // Number of pixels still needed to close the current frame, capped for huge frames.
    function automatic int unsigned pixels_to_frame_end();
        int unsigned r, c, n;
        r = row_pos;
        c = col_pos;
        for (n = 1; n < 5000; n++) begin
            if (c + 1 >= usable_cols(cols_reg)) begin
                c = 0;
                if (r + 1 >= usable_rows(rows_reg)) begin
                    return n;
                end
                r++;
            end else begin
                c++;
            end
        end
        return n;
    endfunction

    // Pixel content styles: full random, black and white only, and a random walk with
    // large or small steps so that weak edges and flat areas both show up.
    function automatic pixel_t next_pixel(int style);
        int step;
        case (style)
            0: begin
                return pixel_t'($urandom_range(0, 255));
            end
            1: begin
                return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            default: begin
                step       = (style == 2) ? 30 : 8;
                walk_level = walk_level + int'($urandom_range(0, 2 * step)) - step;
                if (walk_level < 0) begin
                    walk_level = 0;
                end else if (walk_level > 255) begin
                    walk_level = 255;
                end
                return pixel_t'(walk_level);
            end
        endcase
    endfunction

    task automatic send_pixels(int unsigned n, int style);
        repeat (n) pixel_q.push_back(next_pixel(style));
    endtask

    task automatic queue_register(cfg_reg_t idx, int unsigned v);
        reg_write_q.push_back('{idx, cfg_data_t'(v)});
    endtask

    // Runs the queued register writes back to back on the configuration channel. It is
    // entered at a clock edge; valid stays high between writes and drops after the last.
    task automatic apply_register_writes();
        reg_write_t w;
        while (reg_write_q.size() != 0) begin
            w = reg_write_q.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.index;
            cfg_data  <= w.data;
            do @(posedge aclk); while (!cfg_ready);
            case (w.index)
                REG_FRAME_ROWS:     rows_reg = w.data[ROWS_W-1:0];
                REG_FRAME_COLS:     cols_reg = w.data[COLS_W-1:0];
                REG_LOW_THRESHOLD:  low_thr  = w.data[PIX_W-1:0];
                REG_HIGH_THRESHOLD: high_thr = w.data[PIX_W-1:0];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Holds the sender off until every queued pixel is accepted and every expected result
    // has come back, then lets the three pipeline stages settle before any register write.
    task automatic wait_until_drained();
        do @(posedge aclk);
        while (pixel_q.size() != 0 || pixel_held || expected_edges_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One single-row frame as wide as the line stores. The width register is first written
    // with its nominal maximum, then in the middle of the row with the largest field value,
    // which must act the same.
    task automatic run_wide_frame();
        if (row_pos != 0 || col_pos != 0) begin
            queue_register(REG_FRAME_ROWS, 1);
            apply_register_writes();
            send_pixels(pixels_to_frame_end(), 2);
            wait_until_drained();
        end
        queue_register(REG_FRAME_ROWS, 1);
        queue_register(REG_FRAME_COLS, LINE_DEPTH);
        apply_register_writes();
        send_pixels(LINE_DEPTH / 2, 3);
        wait_until_drained();
        queue_register(REG_FRAME_COLS, COLS_MAX);
        apply_register_writes();
        send_pixels(LINE_DEPTH / 2, 2);
        wait_until_drained();
    endtask

    function automatic int unsigned pick_rows();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return ROWS_MAX;
            default: return $urandom_range(2, 9);
        endcase
    endfunction

    function automatic int unsigned pick_cols();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 2);
            default: return $urandom_range(3, 12);
        endcase
    endfunction

    function automatic int unsigned pick_threshold();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Pixel driver. On each accepted item the predictor runs and its result is queued.
    // Valid only moves when no item is held or the held one is taken at this edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            pixel_held = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_edges_q.push_back(predict_edge(s_pixel));
                pixel_held = 1'b0;
            end
            if (!s_valid || s_ready) begin
                if (pixel_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_pixel    <= pixel_q.pop_front();
                    s_valid    <= 1'b1;
                    pixel_held = 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each accepted item is checked field by field against the oldest
    // expected result; ready stalls at random except in the quiet stretch.
    always @(posedge aclk) begin : result_monitor
        edge_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_edges_q.size() == 0) begin
                    $error("unexpected result item: edge_value %0d, frame_end %0b",
                           m_edge_value, m_frame_end);
                    failures++;
                end else begin
                    want = expected_edges_q.pop_front();
                    if (m_edge_value !== want.edge_value) begin
                        $error("edge_value mismatch: expected %0d, actual %0d",
                               want.edge_value, m_edge_value);
                        failures++;
                    end
                    if (m_frame_end !== want.frame_end) begin
                        $error("frame_end mismatch: expected %0b, actual %0b",
                               want.frame_end, m_frame_end);
                        failures++;
                    end
                end
            end
            m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin : stimulus
        int unsigned random_items;
        int unsigned rem;
        int unsigned n;
        int unsigned frame_pixels;
        int unsigned new_cols;
        int          style;
        bit          shrink_rows;
        bit          wide_done;
        random_items = 0;
        shrink_rows  = 1'b0;
        wide_done    = 1'b0;
        reset_prediction();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: 3x3 frames with one complete window each, at the default thresholds.
        queue_register(REG_FRAME_ROWS, 3);
        queue_register(REG_FRAME_COLS, 3);
        queue_register(REG_LOW_THRESHOLD, LOW_THRESHOLD_RESET);
        queue_register(REG_HIGH_THRESHOLD, HIGH_THRESHOLD_RESET);
        apply_register_writes();
        foreach (DIRECTED_PIXELS[i]) begin
            pixel_q.push_back(DIRECTED_PIXELS[i]);
        end
        wait_until_drained();

        // Random part: phases of register writes followed by pixels. Most phases close the
        // current frame, some stop inside it so the next writes land mid-frame. The wide
        // frame counts toward the item budget.
        while (random_items < RANDOM_ITEMS) begin
            if (!wide_done && random_items >= RANDOM_ITEMS / 4) begin
                run_wide_frame();
                wide_done    = 1'b1;
                random_items += LINE_DEPTH;
            end
            // After a huge frame was cut short, the row count is dropped so the frame ends
            // at the close of the current row.
            if (shrink_rows) begin
                queue_register(REG_FRAME_ROWS, $urandom_range(0, 1));
            end else if ($urandom_range(0, 1)) begin
                queue_register(REG_FRAME_ROWS, pick_rows());
            end
            // The width may grow only at a frame start; otherwise a later row would read
            // line store entries that were never written.
            if ($urandom_range(0, 1)) begin
                new_cols = pick_cols();
                if ((row_pos == 0 && col_pos == 0)
                        || usable_cols(new_cols) <= usable_cols(cols_reg)) begin
                    queue_register(REG_FRAME_COLS, new_cols);
                end
            end
            if ($urandom_range(0, 1)) begin
                queue_register(REG_LOW_THRESHOLD, pick_threshold());
            end
            if ($urandom_range(0, 1)) begin
                queue_register(REG_HIGH_THRESHOLD, pick_threshold());
            end
            apply_register_writes();

            shrink_rows  = 1'b0;
            rem          = pixels_to_frame_end();
            frame_pixels = usable_rows(rows_reg) * usable_cols(cols_reg);
            style        = $urandom_range(0, 3);
            if (rem > 300) begin
                n           = $urandom_range(1, 30);
                shrink_rows = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, rem);
            end else begin
                n = rem;
                if (frame_pixels <= 300) begin
                    n += $urandom_range(0, 2) * frame_pixels;
                end
            end
            send_pixels(n, style);
            random_items += n;
            wait_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_edges_q.size() != 0) begin
            $error("%0d expected result items never arrived", expected_edges_q.size());
            failures++;
        end
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog for a block that stops handshaking.
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
